>>> rtl/assert_macros.svh
// Assertion macros for the RTL files (included by the top level)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted (active-low reset).
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Same, with a caller-supplied message string.
`define ASSERT_CLK_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

`endif

>>> rtl/c8alu_pkg.sv
// Types and constants of the 8-bit execute unit
package c8alu_pkg;

  typedef enum logic [5:0] {
    OP_ADC   = 6'd0,  OP_SBC   = 6'd1,  OP_AND   = 6'd2,  OP_ORA   = 6'd3,
    OP_EOR   = 6'd4,  OP_CMP   = 6'd5,  OP_CPX   = 6'd6,  OP_CPY   = 6'd7,
    OP_BIT   = 6'd8,  OP_LDA   = 6'd9,  OP_LDX   = 6'd10, OP_LDY   = 6'd11,
    OP_ASL_A = 6'd12, OP_ASL_M = 6'd13, OP_LSR_A = 6'd14, OP_LSR_M = 6'd15,
    OP_ROL_A = 6'd16, OP_ROL_M = 6'd17, OP_ROR_A = 6'd18, OP_ROR_M = 6'd19,
    OP_INC_M = 6'd20, OP_DEC_M = 6'd21, OP_INX   = 6'd22, OP_INY   = 6'd23,
    OP_INC_A = 6'd24, OP_DEX   = 6'd25, OP_DEY   = 6'd26, OP_DEC_A = 6'd27,
    OP_STA   = 6'd28, OP_STX   = 6'd29, OP_STY   = 6'd30, OP_STZ   = 6'd31,
    OP_TAX   = 6'd32, OP_TXA   = 6'd33, OP_TAY   = 6'd34, OP_TYA   = 6'd35,
    OP_TSX   = 6'd36, OP_TXS   = 6'd37, OP_CLC   = 6'd38, OP_CLD   = 6'd39,
    OP_CLI   = 6'd40, OP_CLV   = 6'd41, OP_SEC   = 6'd42, OP_SED   = 6'd43,
    OP_SEI   = 6'd44, OP_TRB   = 6'd45, OP_TSB   = 6'd46, OP_RMB   = 6'd47,
    OP_SMB   = 6'd48, OP_NOP   = 6'd49
  } op_e;

  typedef struct packed {
    logic n;
    logic v;
    logic d;
    logic i;
    logic z;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    flags_t     f;
  } regs_t;

  typedef struct packed {
    logic       mem_write;
    logic [7:0] mem_data;
    logic       irq_delay;
  } side_t;

  localparam logic [7:0] SP_RESET      = 8'hFD;
  localparam logic [7:0] BCD_NINES     = 8'h99;
  localparam logic [4:0] BCD_LO_FIX    = 5'h0A;
  localparam logic [4:0] BCD_LO_MAX    = 5'h09;
  localparam logic [9:0] BCD_HI_FIX    = 10'h0A0;
  localparam logic [9:0] BCD_HI_MAX    = 10'h090;
  localparam logic [9:0] BCD_HI_CARRY  = 10'h010;
  localparam logic [7:0] SIGN_MASK     = 8'h80;

  localparam flags_t FLAGS_RESET = '{n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b1, z: 1'b0, c: 1'b0};

endpackage

>>> rtl/cpu8_alu_register_execute.sv
// Top level of the 8-bit execute unit: input register, register file, result register
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------------
//   in      | to unit   | in_valid_i / in_ready_o | kind_i, operand_i, bit_index_i
//   out     | from unit | out_valid_o/out_ready_i | mem_write_o, mem_data_o, acc_out_o,
//           |           |                        | x_out_o, y_out_o, sp_out_o, status_out_o,
//           |           |                        | irq_delay_o
//
// Each transaction is executed in the input register: the register file updates and
// the result register loads at the same edge, so a result moves from the input register
// to the result register; one transaction is taken every cycle unless the output stalls.
// Reset puts A, X, Y at zero, SP at 0xFD and sets only the I flag (status 0x24).
// A stalled output holds the result register, the input register and the register file;
// in_ready_o drops only when the input register is full and cannot advance.
module cpu8_alu_register_execute (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [5:0] kind_i,
  input  logic [7:0] operand_i,
  input  logic [2:0] bit_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       mem_write_o,
  output logic [7:0] mem_data_o,
  output logic [7:0] acc_out_o,
  output logic [7:0] x_out_o,
  output logic [7:0] y_out_o,
  output logic [7:0] sp_out_o,
  output logic [7:0] status_out_o,
  output logic       irq_delay_o
);

  `include "assert_macros.svh"

  // Input register (holds the transaction being executed)
  logic            in_vld_q, in_vld_d;
  logic [5:0]      kind_q;
  logic [7:0]      operand_q;
  logic [2:0]      bit_index_q;

  // Architectural registers
  c8alu_pkg::regs_t regs_q, regs_d;

  // Result register
  logic             out_vld_q, out_vld_d;
  c8alu_pkg::regs_t res_regs_q;
  c8alu_pkg::side_t res_side_q;

  c8alu_pkg::side_t side;
  logic             in_fire;
  logic             exec_go;

  // Execute when the input register is full and the result register is free or draining.
  assign exec_go    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || exec_go;
  assign in_fire    = in_valid_i && in_ready_o;

  c8alu_exec u_exec (
    .op_i        (c8alu_pkg::op_e'(kind_q)),
    .operand_i   (operand_q),
    .bit_index_i (bit_index_q),
    .regs_i      (regs_q),
    .regs_o      (regs_d),
    .side_o      (side)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (exec_go) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (exec_go) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      regs_q.a     <= 8'd0;
      regs_q.x     <= 8'd0;
      regs_q.y     <= 8'd0;
      regs_q.sp    <= c8alu_pkg::SP_RESET;
      regs_q.f     <= c8alu_pkg::FLAGS_RESET;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      // Commit architectural state together with the result.
      if (exec_go) begin
        regs_q <= regs_d;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q      <= kind_i;
      operand_q   <= operand_i;
      bit_index_q <= bit_index_i;
    end
    if (exec_go) begin
      res_regs_q <= regs_d;
      res_side_q <= side;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign mem_write_o  = res_side_q.mem_write;
  assign mem_data_o   = res_side_q.mem_data;
  assign acc_out_o    = res_regs_q.a;
  assign x_out_o      = res_regs_q.x;
  assign y_out_o      = res_regs_q.y;
  assign sp_out_o     = res_regs_q.sp;
  assign status_out_o = {res_regs_q.f.n, res_regs_q.f.v, 1'b1, 1'b0,
                         res_regs_q.f.d, res_regs_q.f.i, res_regs_q.f.z, res_regs_q.f.c};
  assign irq_delay_o  = res_side_q.irq_delay;

  // A transaction taken in always lands in the input register.
  `ASSERT_CLK(a_accept_lands, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> in_vld_q)
  // Backpressure only when the input register is occupied.
  `ASSERT_CLK(a_ready_only_when_full, clk_i, rst_ni, (!in_ready_o) |-> in_vld_q)
  // A stalled result freezes the register file.
  `ASSERT_CLK_MSG(a_stall_freezes_regs, clk_i, rst_ni,
    (out_vld_q && !out_ready_i) |=> $stable(regs_q), "register file moved during stall")
  // No write-back byte without a write strobe.
  `ASSERT_CLK(a_wdata_zero, clk_i, rst_ni, (out_vld_q && !mem_write_o) |-> (mem_data_o == 8'd0))

endmodule

>>> rtl/c8alu_exec.sv
// Combinational execute datapath: one operation against the register file
module c8alu_exec (
  input  c8alu_pkg::op_e   op_i,
  input  logic [7:0]       operand_i,
  input  logic [2:0]       bit_index_i,
  input  c8alu_pkg::regs_t regs_i,
  output c8alu_pkg::regs_t regs_o,
  output c8alu_pkg::side_t side_o
);

  logic       cin;
  logic [7:0] acc;
  logic [7:0] m;
  logic [7:0] v_eff;
  logic [8:0] bin_sum;
  logic [8:0] sub_amt;
  logic [7:0] bin_diff;
  logic [4:0] dec_lo;
  logic [4:0] dec_lo_adj;
  logic [9:0] dec_hi;
  logic [9:0] dec_hi_adj;
  logic [9:0] dec_hi_fin;
  logic       dec_c;
  logic [7:0] dec_r;
  logic [7:0] arith_r;
  logic       arith_c;
  logic [7:0] cmp_reg;
  logic [7:0] cmp_diff;
  logic [7:0] sh_src;
  logic [7:0] bit_mask;

  assign cin = regs_i.f.c;
  assign acc = regs_i.a;
  assign m   = operand_i;

  // Decimal subtract adds the nines complement of the operand.
  assign v_eff = (regs_i.f.d && op_i == c8alu_pkg::OP_SBC) ? c8alu_pkg::BCD_NINES - m : m;

  assign bin_sum  = {1'b0, acc} + {1'b0, m} + {8'd0, cin};
  assign sub_amt  = {1'b0, m} + {8'd0, ~cin};
  assign bin_diff = acc - sub_amt[7:0];

  // Nibble-correct decimal add
  assign dec_lo     = {1'b0, acc[3:0]} + {1'b0, v_eff[3:0]} + {4'd0, cin};
  assign dec_hi     = {2'b00, acc[7:4], 4'h0} + {2'b00, v_eff[7:4], 4'h0};
  assign dec_lo_adj = (dec_lo > c8alu_pkg::BCD_LO_MAX) ? dec_lo - c8alu_pkg::BCD_LO_FIX : dec_lo;
  assign dec_hi_adj = (dec_lo > c8alu_pkg::BCD_LO_MAX) ? dec_hi + c8alu_pkg::BCD_HI_CARRY
                                                       : dec_hi;
  assign dec_c      = dec_hi_adj > c8alu_pkg::BCD_HI_MAX;
  assign dec_hi_fin = dec_c ? dec_hi_adj - c8alu_pkg::BCD_HI_FIX : dec_hi_adj;
  assign dec_r      = dec_hi_fin[7:0] | {4'h0, dec_lo_adj[3:0]};

  always_comb begin
    if (regs_i.f.d) begin
      arith_r = dec_r;
      arith_c = dec_c;
    end else if (op_i == c8alu_pkg::OP_ADC) begin
      arith_r = bin_sum[7:0];
      arith_c = bin_sum[8];
    end else begin
      arith_r = bin_diff;
      arith_c = {1'b0, acc} >= sub_amt;
    end
  end

  always_comb begin
    case (op_i)
      c8alu_pkg::OP_CPX: cmp_reg = regs_i.x;
      c8alu_pkg::OP_CPY: cmp_reg = regs_i.y;
      default:           cmp_reg = acc;
    endcase
  end
  assign cmp_diff = cmp_reg - m;

  assign sh_src   = (op_i inside {c8alu_pkg::OP_ASL_M, c8alu_pkg::OP_LSR_M,
                                  c8alu_pkg::OP_ROL_M, c8alu_pkg::OP_ROR_M}) ? m : acc;
  assign bit_mask = 8'd1 << bit_index_i;

  always_comb begin
    c8alu_pkg::regs_t nx;
    logic             zn_en;
    logic [7:0]       zn_val;
    logic             wr;
    logic [7:0]       wd;
    logic             dly;
    logic [7:0]       sh_r;
    nx     = regs_i;
    zn_en  = 1'b0;
    zn_val = 8'd0;
    wr     = 1'b0;
    wd     = 8'd0;
    dly    = 1'b0;
    sh_r   = 8'd0;
    case (op_i)
      c8alu_pkg::OP_ADC, c8alu_pkg::OP_SBC: begin
        nx.a   = arith_r;
        nx.f.c = arith_c;
        if (op_i == c8alu_pkg::OP_ADC) begin
          nx.f.v = |(~(acc ^ v_eff) & (acc ^ arith_r) & c8alu_pkg::SIGN_MASK);
        end else begin
          nx.f.v = |((acc ^ v_eff) & (acc ^ arith_r) & c8alu_pkg::SIGN_MASK);
        end
        zn_en  = 1'b1;
        zn_val = arith_r;
      end
      c8alu_pkg::OP_AND: begin nx.a = acc & m; zn_en = 1'b1; zn_val = acc & m; end
      c8alu_pkg::OP_ORA: begin nx.a = acc | m; zn_en = 1'b1; zn_val = acc | m; end
      c8alu_pkg::OP_EOR: begin nx.a = acc ^ m; zn_en = 1'b1; zn_val = acc ^ m; end
      c8alu_pkg::OP_CMP, c8alu_pkg::OP_CPX, c8alu_pkg::OP_CPY: begin
        nx.f.c = cmp_reg >= m;
        zn_en  = 1'b1;
        zn_val = cmp_diff;
      end
      c8alu_pkg::OP_BIT: begin
        nx.f.z = (acc & m) == 8'd0;
        nx.f.v = m[6];
        nx.f.n = m[7];
      end
      c8alu_pkg::OP_LDA: begin nx.a = m; zn_en = 1'b1; zn_val = m; end
      c8alu_pkg::OP_LDX: begin nx.x = m; zn_en = 1'b1; zn_val = m; end
      c8alu_pkg::OP_LDY: begin nx.y = m; zn_en = 1'b1; zn_val = m; end
      c8alu_pkg::OP_ASL_A, c8alu_pkg::OP_ASL_M, c8alu_pkg::OP_LSR_A, c8alu_pkg::OP_LSR_M,
      c8alu_pkg::OP_ROL_A, c8alu_pkg::OP_ROL_M, c8alu_pkg::OP_ROR_A, c8alu_pkg::OP_ROR_M: begin
        if (op_i inside {c8alu_pkg::OP_ASL_A, c8alu_pkg::OP_ASL_M}) begin
          sh_r = {sh_src[6:0], 1'b0};
          nx.f.c = sh_src[7];
        end else if (op_i inside {c8alu_pkg::OP_ROL_A, c8alu_pkg::OP_ROL_M}) begin
          sh_r = {sh_src[6:0], cin};
          nx.f.c = sh_src[7];
        end else if (op_i inside {c8alu_pkg::OP_LSR_A, c8alu_pkg::OP_LSR_M}) begin
          sh_r = {1'b0, sh_src[7:1]};
          nx.f.c = sh_src[0];
        end else begin
          sh_r = {cin, sh_src[7:1]};
          nx.f.c = sh_src[0];
        end
        zn_en  = 1'b1;
        zn_val = sh_r;
        if (op_i inside {c8alu_pkg::OP_ASL_M, c8alu_pkg::OP_LSR_M,
                         c8alu_pkg::OP_ROL_M, c8alu_pkg::OP_ROR_M}) begin
          wr = 1'b1;
          wd = sh_r;
        end else begin
          nx.a = sh_r;
        end
      end
      c8alu_pkg::OP_INC_M: begin
        wr = 1'b1; wd = m + 8'd1; zn_en = 1'b1; zn_val = m + 8'd1;
      end
      c8alu_pkg::OP_DEC_M: begin
        wr = 1'b1; wd = m - 8'd1; zn_en = 1'b1; zn_val = m - 8'd1;
      end
      c8alu_pkg::OP_INX: begin
        nx.x = regs_i.x + 8'd1; zn_en = 1'b1; zn_val = regs_i.x + 8'd1;
      end
      c8alu_pkg::OP_INY: begin
        nx.y = regs_i.y + 8'd1; zn_en = 1'b1; zn_val = regs_i.y + 8'd1;
      end
      c8alu_pkg::OP_INC_A: begin
        nx.a = acc + 8'd1; zn_en = 1'b1; zn_val = acc + 8'd1;
      end
      c8alu_pkg::OP_DEX: begin
        nx.x = regs_i.x - 8'd1; zn_en = 1'b1; zn_val = regs_i.x - 8'd1;
      end
      c8alu_pkg::OP_DEY: begin
        nx.y = regs_i.y - 8'd1; zn_en = 1'b1; zn_val = regs_i.y - 8'd1;
      end
      c8alu_pkg::OP_DEC_A: begin
        nx.a = acc - 8'd1; zn_en = 1'b1; zn_val = acc - 8'd1;
      end
      c8alu_pkg::OP_STA: begin wr = 1'b1; wd = acc;      end
      c8alu_pkg::OP_STX: begin wr = 1'b1; wd = regs_i.x; end
      c8alu_pkg::OP_STY: begin wr = 1'b1; wd = regs_i.y; end
      c8alu_pkg::OP_STZ: begin wr = 1'b1; wd = 8'd0;     end
      c8alu_pkg::OP_TAX: begin nx.x = acc;       zn_en = 1'b1; zn_val = acc;       end
      c8alu_pkg::OP_TXA: begin nx.a = regs_i.x;  zn_en = 1'b1; zn_val = regs_i.x;  end
      c8alu_pkg::OP_TAY: begin nx.y = acc;       zn_en = 1'b1; zn_val = acc;       end
      c8alu_pkg::OP_TYA: begin nx.a = regs_i.y;  zn_en = 1'b1; zn_val = regs_i.y;  end
      c8alu_pkg::OP_TSX: begin nx.x = regs_i.sp; zn_en = 1'b1; zn_val = regs_i.sp; end
      c8alu_pkg::OP_TXS: nx.sp = regs_i.x;
      c8alu_pkg::OP_CLC: nx.f.c = 1'b0;
      c8alu_pkg::OP_CLD: nx.f.d = 1'b0;
      c8alu_pkg::OP_CLI: begin nx.f.i = 1'b0; dly = 1'b1; end
      c8alu_pkg::OP_CLV: nx.f.v = 1'b0;
      c8alu_pkg::OP_SEC: nx.f.c = 1'b1;
      c8alu_pkg::OP_SED: nx.f.d = 1'b1;
      c8alu_pkg::OP_SEI: begin nx.f.i = 1'b1; dly = 1'b1; end
      c8alu_pkg::OP_TRB: begin
        zn_en = 1'b1; zn_val = acc & m; wr = 1'b1; wd = m & ~acc;
      end
      c8alu_pkg::OP_TSB: begin
        zn_en = 1'b1; zn_val = acc & m; wr = 1'b1; wd = m | acc;
      end
      c8alu_pkg::OP_RMB: begin wr = 1'b1; wd = m & ~bit_mask; end
      c8alu_pkg::OP_SMB: begin wr = 1'b1; wd = m | bit_mask;  end
      default: ;
    endcase
    if (zn_en) begin
      nx.f.z = zn_val == 8'd0;
      nx.f.n = zn_val[7];
    end
    regs_o           = nx;
    side_o.mem_write = wr;
    side_o.mem_data  = wd;
    side_o.irq_delay = dly;
  end

endmodule

>>> test/exec_scoreboard_pkg.sv
// Scoreboard: register-file tracker and result checker for the 8-bit execute unit
`timescale 1ns / 100ps

package exec_scoreboard_pkg;
  import c8alu_pkg::*;

  // Codes outside the operation set; the unit treats them as no-ops
  localparam logic [5:0] KIND_UNUSED_FIRST = 6'd50;
  localparam logic [5:0] KIND_UNUSED_LAST  = 6'd63;

  typedef struct {
    logic       mem_write;
    logic [7:0] mem_data;
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] status;
    logic       irq_delay;
  } exec_result_t;

  class exec_scoreboard;
    logic [7:0]   acc;
    logic [7:0]   xr;
    logic [7:0]   yr;
    logic [7:0]   spr;
    flags_t       fl;
    exec_result_t pending_results[$];
    int unsigned  errors;

    function new();
      acc    = 8'h00;
      xr     = 8'h00;
      yr     = 8'h00;
      spr    = SP_RESET;
      fl     = FLAGS_RESET;
      errors = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_zn(logic [7:0] v);
      fl.z = (v == 8'h00);
      fl.n = v[7];
    endfunction

    // Shift or rotate one byte; carry out goes to C, carry in comes from C
    function logic [7:0] shift_byte(logic [5:0] k, logic [7:0] v);
      logic [7:0] r;
      logic       cin;
      cin = fl.c;
      case (k)
        OP_ASL_A, OP_ASL_M: begin
          fl.c = v[7];
          r    = {v[6:0], 1'b0};
        end
        OP_LSR_A, OP_LSR_M: begin
          fl.c = v[0];
          r    = {1'b0, v[7:1]};
        end
        OP_ROL_A, OP_ROL_M: begin
          fl.c = v[7];
          r    = {v[6:0], cin};
        end
        default: begin
          fl.c = v[0];
          r    = {cin, v[7:1]};
        end
      endcase
      set_zn(r);
      return r;
    endfunction

    // Advance the tracked registers by one accepted operation and queue its result
    function void note_op(logic [5:0] k, logic [7:0] opd, logic [2:0] bi);
      exec_result_t res;
      logic [7:0]   a;
      logic [7:0]   v;
      logic [7:0]   r;
      logic         cin;
      int           lo;
      int           hi;
      int           s;
      int           sub;
      res.mem_write = 1'b0;
      res.mem_data  = 8'h00;
      res.irq_delay = 1'b0;
      a   = acc;
      cin = fl.c;
      case (k)
        OP_ADC, OP_SBC: begin
          v = opd;
          if (fl.d) begin
            if (k == OP_SBC) v = BCD_NINES - opd;
            lo = int'(a[3:0]) + int'(v[3:0]) + int'(cin);
            hi = int'(a & 8'hF0) + int'(v & 8'hF0);
            if (lo > int'(BCD_LO_MAX)) begin
              lo -= int'(BCD_LO_FIX);
              hi += int'(BCD_HI_CARRY);
            end
            fl.c = 1'b0;
            if (hi > int'(BCD_HI_MAX)) begin
              hi -= int'(BCD_HI_FIX);
              fl.c = 1'b1;
            end
            r = 8'(hi | (lo & 'hF));
          end else if (k == OP_ADC) begin
            s    = int'(a) + int'(v) + int'(cin);
            fl.c = (s > 255);
            r    = 8'(s);
          end else begin
            sub  = int'(v) + (1 - int'(cin));
            fl.c = (int'(a) >= sub);
            r    = 8'(int'(a) - sub);
          end
          if (k == OP_ADC) fl.v = (((~(a ^ v)) & (a ^ r) & SIGN_MASK) != 8'h00);
          else             fl.v = (((a ^ v) & (a ^ r) & SIGN_MASK) != 8'h00);
          set_zn(r);
          acc = r;
        end
        OP_AND: begin acc = a & opd; set_zn(acc); end
        OP_ORA: begin acc = a | opd; set_zn(acc); end
        OP_EOR: begin acc = a ^ opd; set_zn(acc); end
        OP_CMP: begin fl.c = (a >= opd);  set_zn(a - opd);  end
        OP_CPX: begin fl.c = (xr >= opd); set_zn(xr - opd); end
        OP_CPY: begin fl.c = (yr >= opd); set_zn(yr - opd); end
        OP_BIT: begin
          fl.z = ((a & opd) == 8'h00);
          fl.v = opd[6];
          fl.n = opd[7];
        end
        OP_LDA: begin acc = opd; set_zn(opd); end
        OP_LDX: begin xr = opd;  set_zn(opd); end
        OP_LDY: begin yr = opd;  set_zn(opd); end
        OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: acc = shift_byte(k, a);
        OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
          res.mem_data  = shift_byte(k, opd);
          res.mem_write = 1'b1;
        end
        OP_INC_M: begin res.mem_data = opd + 8'd1; set_zn(res.mem_data); res.mem_write = 1'b1; end
        OP_DEC_M: begin res.mem_data = opd - 8'd1; set_zn(res.mem_data); res.mem_write = 1'b1; end
        OP_INX:   begin xr  = xr + 8'd1;  set_zn(xr);  end
        OP_INY:   begin yr  = yr + 8'd1;  set_zn(yr);  end
        OP_INC_A: begin acc = a + 8'd1;   set_zn(acc); end
        OP_DEX:   begin xr  = xr - 8'd1;  set_zn(xr);  end
        OP_DEY:   begin yr  = yr - 8'd1;  set_zn(yr);  end
        OP_DEC_A: begin acc = a - 8'd1;   set_zn(acc); end
        OP_STA: begin res.mem_data = a;     res.mem_write = 1'b1; end
        OP_STX: begin res.mem_data = xr;    res.mem_write = 1'b1; end
        OP_STY: begin res.mem_data = yr;    res.mem_write = 1'b1; end
        OP_STZ: begin res.mem_data = 8'h00; res.mem_write = 1'b1; end
        OP_TAX: begin xr  = a;   set_zn(a);   end
        OP_TXA: begin acc = xr;  set_zn(xr);  end
        OP_TAY: begin yr  = a;   set_zn(a);   end
        OP_TYA: begin acc = yr;  set_zn(yr);  end
        OP_TSX: begin xr  = spr; set_zn(spr); end
        OP_TXS: spr = xr;
        OP_CLC: fl.c = 1'b0;
        OP_CLD: fl.d = 1'b0;
        OP_CLI: begin fl.i = 1'b0; res.irq_delay = 1'b1; end
        OP_CLV: fl.v = 1'b0;
        OP_SEC: fl.c = 1'b1;
        OP_SED: fl.d = 1'b1;
        OP_SEI: begin fl.i = 1'b1; res.irq_delay = 1'b1; end
        OP_TRB: begin
          set_zn(a & opd);
          res.mem_data  = opd & ~a;
          res.mem_write = 1'b1;
        end
        OP_TSB: begin
          set_zn(a & opd);
          res.mem_data  = opd | a;
          res.mem_write = 1'b1;
        end
        OP_RMB: begin res.mem_data = opd & ~(8'h01 << bi); res.mem_write = 1'b1; end
        OP_SMB: begin res.mem_data = opd | (8'h01 << bi);  res.mem_write = 1'b1; end
        default: ;
      endcase
      res.acc    = acc;
      res.x      = xr;
      res.y      = yr;
      res.sp     = spr;
      res.status = {fl.n, fl.v, 1'b1, 1'b0, fl.d, fl.i, fl.z, fl.c};
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one delivered result with the oldest queued prediction
    function void check_result(exec_result_t got);
      exec_result_t want;
      if (pending_results.size() == 0) begin
        $error("result delivered with no prediction queued");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("mem_write",  8'(want.mem_write), 8'(got.mem_write));
      compare_field("mem_data",   want.mem_data,      got.mem_data);
      compare_field("acc_out",    want.acc,           got.acc);
      compare_field("x_out",      want.x,             got.x);
      compare_field("y_out",      want.y,             got.y);
      compare_field("sp_out",     want.sp,            got.sp);
      compare_field("status_out", want.status,        got.status);
      compare_field("irq_delay",  8'(want.irq_delay), 8'(got.irq_delay));
    endfunction
  endclass

endpackage

>>> test/testbench.sv
// Top-level testbench of the 8-bit execute unit
`timescale 1ns / 100ps

module testbench;

  // Watchdog limit; keep a wide margin over the slowest case
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_OPS   = 872;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [5:0] kind_i;
  logic [7:0] operand_i;
  logic [2:0] bit_index_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       mem_write_o;
  logic [7:0] mem_data_o;
  logic [7:0] acc_out_o;
  logic [7:0] x_out_o;
  logic [7:0] y_out_o;
  logic [7:0] sp_out_o;
  logic [7:0] status_out_o;
  logic       irq_delay_o;

  exec_scoreboard_pkg::exec_scoreboard sb;
  int unsigned    cycle_count = 0;
  // Stretches with no idling on the input and output side
  bit             in_burst    = 1'b0;
  bit             out_burst   = 1'b0;

  cpu8_alu_register_execute i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .operand_i    (operand_i),
    .bit_index_i  (bit_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mem_write_o  (mem_write_o),
    .mem_data_o   (mem_data_o),
    .acc_out_o    (acc_out_o),
    .x_out_o      (x_out_o),
    .y_out_o      (y_out_o),
    .sp_out_o     (sp_out_o),
    .status_out_o (status_out_o),
    .irq_delay_o  (irq_delay_o)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: end the run if the unit stops moving transactions
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cpu8_alu_register_execute verification failed");
      $finish;
    end
  end

  // Present one transaction after a random gap and hold it until accepted.
  // With a zero gap valid stays high across the edge, so it is never lowered here.
  task automatic send_op(input logic [5:0] k, input logic [7:0] opd, input logic [2:0] bi);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    operand_i   <= opd;
    bit_index_i <= bi;
    // Signals read right after the edge still hold their pre-edge values
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_op(k, opd, bi);
  endtask

  // Drain results forever, stalling for a random number of cycles before each
  task automatic collect_results();
    int unsigned                       gap;
    exec_scoreboard_pkg::exec_result_t got;
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.mem_write = mem_write_o;
      got.mem_data  = mem_data_o;
      got.acc       = acc_out_o;
      got.x         = x_out_o;
      got.y         = y_out_o;
      got.sp        = sp_out_o;
      got.status    = status_out_o;
      got.irq_delay = irq_delay_o;
      sb.check_result(got);
    end
  endtask

  // Hit carry, overflow, zero and sign edges, decimal wrap, BIT on an
  // immediate value, stack transfers, bit set/reset and an unused code
  task automatic run_directed();
    send_op(c8alu_pkg::OP_LDA,   8'h00, 3'd0);
    send_op(c8alu_pkg::OP_LDA,   8'hFF, 3'd0);
    send_op(c8alu_pkg::OP_ADC,   8'h01, 3'd0);   // wrap to zero, carry out
    send_op(c8alu_pkg::OP_ADC,   8'h7F, 3'd0);   // positive overflow into 0x80
    send_op(c8alu_pkg::OP_SBC,   8'h01, 3'd0);   // borrow in, negative overflow
    send_op(c8alu_pkg::OP_SEC,   8'h00, 3'd0);
    send_op(c8alu_pkg::OP_SBC,   8'hFF, 3'd0);
    send_op(c8alu_pkg::OP_LDX,   8'hFF, 3'd0);
    send_op(c8alu_pkg::OP_CPX,   8'hFF, 3'd0);
    send_op(c8alu_pkg::OP_CMP,   8'h00, 3'd0);
    send_op(c8alu_pkg::OP_BIT,   8'hC0, 3'd0);   // N and V taken straight from the immediate
    send_op(c8alu_pkg::OP_SED,   8'h00, 3'd0);
    send_op(c8alu_pkg::OP_LDA,   8'h99, 3'd0);
    send_op(c8alu_pkg::OP_ADC,   8'h01, 3'd0);   // decimal 99 + 1 plus carry in wraps with carry
    send_op(c8alu_pkg::OP_SBC,   8'h01, 3'd0);   // decimal subtract through nines complement
    send_op(c8alu_pkg::OP_ADC,   8'hFF, 3'd0);   // non-decimal digits in decimal mode
    send_op(c8alu_pkg::OP_CLD,   8'h00, 3'd0);
    send_op(c8alu_pkg::OP_TXS,   8'h00, 3'd0);
    send_op(c8alu_pkg::OP_TSX,   8'h00, 3'd0);
    send_op(c8alu_pkg::OP_CLI,   8'h00, 3'd0);
    send_op(c8alu_pkg::OP_SEI,   8'h00, 3'd0);
    send_op(c8alu_pkg::OP_ASL_M, 8'h80, 3'd0);
    send_op(c8alu_pkg::OP_ROR_A, 8'h00, 3'd0);
    send_op(c8alu_pkg::OP_RMB,   8'hFF, 3'd7);
    send_op(c8alu_pkg::OP_SMB,   8'h00, 3'd0);
    send_op(c8alu_pkg::OP_TRB,   8'hFF, 3'd0);
    send_op(exec_scoreboard_pkg::KIND_UNUSED_LAST, 8'hA5, 3'd5);
    send_op(c8alu_pkg::OP_STZ,   8'h5A, 3'd0);
  endtask

  // Lean on add/subtract and flag control so decimal mode and carry chains get deep
  // coverage; unused codes are thrown in as noise
  task automatic run_random();
    int unsigned counted;
    int unsigned pick;
    logic [5:0]  k;
    logic [7:0]  opd;
    counted = 0;
    while (counted < RANDOM_OPS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        k = 6'($urandom_range(exec_scoreboard_pkg::KIND_UNUSED_FIRST,
                              exec_scoreboard_pkg::KIND_UNUSED_LAST));
      end else if (pick < 35) begin
        k = ($urandom_range(0, 1) == 0) ? c8alu_pkg::OP_ADC : c8alu_pkg::OP_SBC;
      end else if (pick < 45) begin
        case ($urandom_range(0, 3))
          0:       k = c8alu_pkg::OP_SED;
          1:       k = c8alu_pkg::OP_CLD;
          2:       k = c8alu_pkg::OP_SEC;
          default: k = c8alu_pkg::OP_CLC;
        endcase
      end else k = 6'($urandom_range(0, c8alu_pkg::OP_NOP));
      // Valid decimal digits a third of the time, any byte otherwise
      if ($urandom_range(0, 2) == 0) opd = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      else                           opd = 8'($urandom);
      send_op(k, opd, 3'($urandom_range(0, 7)));
      counted++;
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    out_ready_i <= 1'b0;
    kind_i      <= c8alu_pkg::OP_NOP;
    operand_i   <= 8'h00;
    bit_index_i <= 3'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fork
      collect_results();
    join_none

    run_directed();
    run_random();
    in_valid_i <= 1'b0;

    // Wait for every predicted result, then watch for strays through the drain interval
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("cpu8_alu_register_execute verification clean");
    end else begin
      $display("cpu8_alu_register_execute verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/c8alu_pkg.sv
rtl/c8alu_exec.sv
rtl/cpu8_alu_register_execute.sv
test/exec_scoreboard_pkg.sv
test/testbench.sv
